/* rtl/core/fbla_pkg.sv */
// ----------------------------------------------------------------------------
// fbla_pkg
// Shared widths, codes and defaults for the fixed-size block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package fbla_pkg;

  // Field widths
  localparam int COUNT_W  = 11;
  localparam int ESIZE_W  = 13;
  localparam int BLK_W    = 10;
  localparam int OFFSET_W = 22;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  // Configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // Defaults
  localparam int DEF_POOL_DEPTH = 1024;
  localparam logic [COUNT_W-1:0] POOL_COUNT_RST   = 11'd1024;
  localparam logic [ESIZE_W-1:0] ELEMENT_SIZE_RST = 13'd64;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [BLK_W-1:0]    blk_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [ESIZE_W-1:0]  esize_t;

  // Command codes
  localparam cmd_t CMD_INIT  = 2'd0;
  localparam cmd_t CMD_ALLOC = 2'd1;
  localparam cmd_t CMD_FREE  = 2'd2;

  // Status codes
  localparam status_t STAT_DONE      = 2'd0;
  localparam status_t STAT_EMPTY     = 2'd1;
  localparam status_t STAT_NULL_FREE = 2'd2;

  // Register indexes
  localparam logic REG_POOL_COUNT   = 1'b0;
  localparam logic REG_ELEMENT_SIZE = 1'b1;

endpackage : fbla_pkg

`default_nettype wire

/* rtl/core/fbla_req_if.sv */
// ----------------------------------------------------------------------------
// fbla_req_if
// Request channel of the block allocator: command and optional block index.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbla_req_if;
  import fbla_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   command;
  logic   has_block;
  blk_t   block_index;

  modport source (output valid, output command, output has_block,
                  output block_index, input ready);
  modport sink   (input valid, input command, input has_block,
                  input block_index, output ready);
endinterface : fbla_req_if

`default_nettype wire

/* rtl/core/fbla_rsp_if.sv */
// ----------------------------------------------------------------------------
// fbla_rsp_if
// Response channel of the block allocator: grant, index, offset and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface fbla_rsp_if;
  import fbla_pkg::*;

  logic    valid;
  logic    ready;
  logic    granted;
  blk_t    given_index;
  offset_t byte_offset;
  status_t status;

  modport source (output valid, output granted, output given_index,
                  output byte_offset, output status, input ready);
  modport sink   (input valid, input granted, input given_index,
                  input byte_offset, input status, output ready);
endinterface : fbla_rsp_if

`default_nettype wire

/* rtl/core/fbla_ram.sv */
// ----------------------------------------------------------------------------
// fbla_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fbla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, then register the read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : fbla_ram

`default_nettype wire

/* rtl/core/fixed_block_free_list_allocator.sv */
// Free, null free, empty allocate and unused codes answer in the cycle after the
// request is taken; a granted allocate first passes S_ALLOC (link memory read).
// Init walks n = min(pool_count, POOL_DEPTH) blocks in S_INIT, one link write per
// cycle through the single write port. One request is in work at a time.
// Reset (rst, synchronous): the free list is empty, pool_count = 1024,
// element_size = 64; link memory contents stay undefined until written.
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool kept as a singly linked free list in a link RAM.
// Allocate pops the head, free pushes a block, init links the whole pool.
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_block_free_list_allocator #(
  parameter int POOL_DEPTH = fbla_pkg::DEF_POOL_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  fbla_req_if.sink                           req,
  fbla_rsp_if.source                         rsp,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [fbla_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [fbla_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [fbla_pkg::APB_DATA_W-1:0] prdata,
  output logic                               pready
);
  import fbla_pkg::*;

  localparam int AW     = $clog2(POOL_DEPTH);
  localparam int CNT_W  = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;
  localparam int PROD_W = (AW + ESIZE_W > OFFSET_W) ? AW + ESIZE_W : OFFSET_W;
  localparam int LINK_W = AW + 1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_INIT  = 3'b010,
    S_ALLOC = 3'b100
  } state_t;

  state_t          state, state_next;
  count_t          pool_count;
  esize_t          element_size;
  logic            head_valid;
  logic [AW-1:0]   head_link;
  logic [AW-1:0]   sweep_idx;
  logic [AW-1:0]   sweep_last;

  logic            out_valid;
  logic            out_granted;
  blk_t            out_index;
  offset_t         out_offset;
  status_t         out_status;

  logic            accept;
  logic            cfg_wr;
  logic [CNT_W-1:0] depth_c;
  logic [CNT_W-1:0] count_ext;
  logic [CNT_W-1:0] count_clamp;
  logic [CNT_W-1:0] count_minus;
  logic [CNT_W-1:0] blk_ext;
  logic [CNT_W-1:0] got_ext;
  logic            blk_ok;
  logic            free_ok;
  logic [PROD_W-1:0] product;

  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [LINK_W-1:0] mem_wdata;
  logic [LINK_W-1:0] mem_rdata;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_count   <= POOL_COUNT_RST;
      element_size <= ELEMENT_SIZE_RST;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_POOL_COUNT:   pool_count   <= pwdata[COUNT_W-1:0];
        REG_ELEMENT_SIZE: element_size <= pwdata[ESIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_POOL_COUNT:   prdata = APB_DATA_W'(pool_count);
      REG_ELEMENT_SIZE: prdata = APB_DATA_W'(element_size);
      default:          prdata = '0;
    endcase
  end

  // Request handshake: take a new request only when idle and the result slot frees
  assign req.ready = (state == S_IDLE) && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  // Init bounds and free range check
  assign depth_c     = CNT_W'(POOL_DEPTH);
  assign count_ext   = CNT_W'(pool_count);
  assign count_clamp = (count_ext > depth_c) ? depth_c : count_ext;
  assign count_minus = count_clamp - CNT_W'(1);
  assign blk_ext     = CNT_W'(req.block_index);
  assign blk_ok      = blk_ext < depth_c;
  assign free_ok     = req.has_block && blk_ok;

  // Byte offset of the block leaving the head
  assign product = PROD_W'(head_link) * PROD_W'(element_size);
  assign got_ext = CNT_W'(head_link);

  // Link memory write: init sweep or push of a freed block
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep_idx;
    mem_wdata = {(sweep_idx != sweep_last), sweep_idx + AW'(1)};
    if (state == S_INIT) begin
      mem_we = 1'b1;
      if (sweep_idx == sweep_last) begin
        mem_wdata = '0;
      end
    end else if (accept && req.command == CMD_FREE && free_ok) begin
      mem_we    = 1'b1;
      mem_waddr = blk_ext[AW-1:0];
      mem_wdata = head_valid ? {1'b1, head_link} : '0;
    end
  end

  fbla_ram #(
    .WIDTH (LINK_W),
    .DEPTH (POOL_DEPTH)
  ) u_links (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (head_link),
    .rdata (mem_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (req.command == CMD_INIT && count_clamp != '0) begin
            state_next = S_INIT;
          end else if (req.command == CMD_ALLOC && head_valid) begin
            state_next = S_ALLOC;
          end
        end
      end
      S_INIT: begin
        if (sweep_idx == sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_ALLOC:  state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Head of the free list
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      head_link  <= '0;
    end else if (state == S_ALLOC) begin
      head_valid <= mem_rdata[LINK_W-1];
      head_link  <= mem_rdata[AW-1:0];
    end else if (accept) begin
      case (req.command)
        CMD_INIT: begin
          head_valid <= (count_clamp != '0);
          head_link  <= '0;
        end
        CMD_FREE: begin
          if (free_ok) begin
            head_valid <= 1'b1;
            head_link  <= blk_ext[AW-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Init sweep counter
  always_ff @(posedge clk) begin
    if (accept && req.command == CMD_INIT) begin
      sweep_idx  <= '0;
      sweep_last <= count_minus[AW-1:0];
    end else if (state == S_INIT) begin
      sweep_idx <= sweep_idx + AW'(1);
    end
  end

  // Result register: load on completion, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_ALLOC) begin
      out_valid   <= 1'b1;
      out_granted <= 1'b1;
      out_index   <= got_ext[BLK_W-1:0];
      out_offset  <= product[OFFSET_W-1:0];
      out_status  <= STAT_DONE;
    end else if (state == S_INIT && sweep_idx == sweep_last) begin
      out_valid   <= 1'b1;
      out_granted <= 1'b0;
      out_index   <= '0;
      out_offset  <= '0;
      out_status  <= STAT_DONE;
    end else if (accept) begin
      out_granted <= 1'b0;
      out_index   <= '0;
      out_offset  <= '0;
      case (req.command)
        CMD_INIT: begin
          // zero count finishes at once
          out_valid  <= (count_clamp == '0);
          out_status <= STAT_DONE;
        end
        CMD_ALLOC: begin
          out_valid  <= !head_valid;
          out_status <= head_valid ? STAT_DONE : STAT_EMPTY;
        end
        CMD_FREE: begin
          out_valid  <= 1'b1;
          out_status <= free_ok ? STAT_DONE : STAT_NULL_FREE;
        end
        default: begin
          out_valid  <= 1'b1;
          out_status <= STAT_DONE;
        end
      endcase
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.granted     = out_granted;
  assign rsp.given_index = out_index;
  assign rsp.byte_offset = out_offset;
  assign rsp.status      = out_status;

endmodule : fixed_block_free_list_allocator

`default_nettype wire

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fixed-size block pool allocator. A driver feeds
// queued requests, a monitor checks every answer against a shadow free list
// kept in the bench, and the pool is reconfigured over the APB port between
// phases. Directed requests cover the corner cases; random phases then mix
// well-formed allocate/free traffic with null frees, double frees and unused
// command codes, under random gaps, stalls and long receiver hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  import fbla_pkg::*;

  localparam int   DEPTH        = DEF_POOL_DEPTH;
  localparam cmd_t CMD_UNUSED   = 2'd3;
  localparam int   RANDOM_ITEMS = 1150;
  localparam int   QUIET_LIMIT  = 6000;
  localparam int   HOLD_LEN     = 300;
  localparam int   HOLD_FIRST   = 150;
  localparam int   HOLD_EVERY   = 500;

  typedef struct packed {
    cmd_t cmd;
    logic has;
    blk_t blk;
  } alloc_req_t;

  typedef struct packed {
    logic    granted;
    blk_t    index;
    offset_t offset;
    status_t status;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fbla_req_if req_ch ();
  fbla_rsp_if rsp_ch ();

  fixed_block_free_list_allocator u_dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the pool: configuration and free list
  count_t cfg_count = POOL_COUNT_RST;
  esize_t cfg_esize = ELEMENT_SIZE_RST;
  bit     fl_head_ok = 1'b0;
  blk_t   fl_head    = '0;
  bit     fl_next_ok [DEPTH];
  blk_t   fl_next    [DEPTH];

  alloc_req_t req_backlog [$];
  alloc_rsp_t answers_due [$];

  // Stimulus-side mirror of the list, used only to pick sensible frees
  int gen_free [$];
  int gen_held [$];

  int  err_cnt   = 0;
  int  acc_count = 0;
  int  gap_cnt   = 0;
  int  stall_cnt = 0;
  int  hold_cnt  = 0;
  int  hold_mark = HOLD_FIRST;
  int  quiet     = 0;
  bit  no_idle   = 1'b0;
  alloc_rsp_t want_rsp;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // Advance the shadow free list by one request and return its answer
  function automatic alloc_rsp_t free_list_step(alloc_req_t rq);
    alloc_rsp_t ans;
    int n;
    blk_t got;
    ans = '0;
    ans.status = STAT_DONE;
    case (rq.cmd)
      CMD_INIT: begin
        n = (cfg_count > DEPTH) ? DEPTH : int'(cfg_count);
        for (int i = 0; i < n; i++) begin
          fl_next_ok[i] = (i + 1 < n);
          fl_next[i]    = (i + 1 < n) ? blk_t'(i + 1) : '0;
        end
        fl_head_ok = (n != 0);
        fl_head    = '0;
      end
      CMD_ALLOC: begin
        if (fl_head_ok) begin
          got         = fl_head;
          ans.granted = 1'b1;
          ans.index   = got;
          ans.offset  = offset_t'(32'(got) * 32'(cfg_esize));
          fl_head_ok  = fl_next_ok[got];
          fl_head     = fl_next[got];
        end else begin
          ans.status = STAT_EMPTY;
        end
      end
      CMD_FREE: begin
        if (!rq.has) begin
          ans.status = STAT_NULL_FREE;
        end else begin
          fl_next_ok[rq.blk] = fl_head_ok;
          fl_next[rq.blk]    = fl_head_ok ? fl_head : '0;
          fl_head_ok         = 1'b1;
          fl_head            = rq.blk;
        end
      end
      default: ;
    endcase
    return ans;
  endfunction

  function automatic void queue_item(cmd_t c, logic h, blk_t b);
    alloc_req_t it;
    it.cmd = c;
    it.has = h;
    it.blk = b;
    req_backlog.push_back(it);
  endfunction

  task automatic flag_field(string what, logic [31:0] want, logic [31:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    err_cnt++;
  endtask

  // Write one register over APB, then read it back
  task automatic write_reg(input logic which, input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] seen;
    logic [APB_DATA_W-1:0] mask;
    mask = (which == REG_POOL_COUNT) ? APB_DATA_W'((1 << COUNT_W) - 1)
                                     : APB_DATA_W'((1 << ESIZE_W) - 1);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {which, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (which == REG_POOL_COUNT) cfg_count = count_t'(value);
    else cfg_esize = esize_t'(value);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((seen & mask) !== (value & mask)) flag_field("register readback", value, seen);
  endtask

  task automatic set_config(input int count, input int esize);
    write_reg(REG_POOL_COUNT, APB_DATA_W'(count));
    write_reg(REG_ELEMENT_SIZE, APB_DATA_W'(esize));
  endtask

  // Hold until every queued request is in and every answer is back
  task automatic wait_idle();
    do @(posedge clk);
    while (req_backlog.size() != 0 || req_ch.valid || answers_due.size() != 0);
  endtask

  // Request driver: predict on acceptance, hold while stalled, then advance
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid       <= 1'b0;
      req_ch.command     <= CMD_INIT;
      req_ch.has_block   <= 1'b0;
      req_ch.block_index <= '0;
      gap_cnt            <= 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        answers_due.push_back(free_list_step({req_ch.command, req_ch.has_block,
                                              req_ch.block_index}));
        acc_count <= acc_count + 1;
      end
      if (req_ch.valid && !req_ch.ready) begin
        // hold the current request
      end else if (gap_cnt != 0) begin
        gap_cnt      <= gap_cnt - 1;
        req_ch.valid <= 1'b0;
      end else if (req_backlog.size() != 0) begin
        req_ch.command     <= req_backlog[0].cmd;
        req_ch.has_block   <= req_backlog[0].has;
        req_ch.block_index <= req_backlog[0].blk;
        req_ch.valid       <= 1'b1;
        void'(req_backlog.pop_front());
        gap_cnt <= gap_len();
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, repeated as traffic goes on
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt  <= 0;
      hold_mark <= HOLD_FIRST;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (acc_count >= hold_mark) begin
      hold_cnt  <= HOLD_LEN;
      hold_mark <= hold_mark + HOLD_EVERY;
    end
  end

  // Response monitor: check against the oldest prediction, then pick ready
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_cnt    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (answers_due.size() == 0) begin
          $display("%0t: response with no request outstanding", $time);
          err_cnt++;
        end else begin
          want_rsp = answers_due.pop_front();
          if (rsp_ch.granted !== want_rsp.granted)
            flag_field("granted", want_rsp.granted, rsp_ch.granted);
          if (rsp_ch.given_index !== want_rsp.index)
            flag_field("given_index", want_rsp.index, rsp_ch.given_index);
          if (rsp_ch.byte_offset !== want_rsp.offset)
            flag_field("byte_offset", want_rsp.offset, rsp_ch.byte_offset);
          if (rsp_ch.status !== want_rsp.status)
            flag_field("status", want_rsp.status, rsp_ch.status);
        end
      end
      if (hold_cnt != 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_cnt != 0) begin
        stall_cnt    <= stall_cnt - 1;
        rsp_ch.ready <= 1'b0;
      end else if ((rsp_ch.valid && rsp_ch.ready) || $urandom_range(0, 15) == 0) begin
        stall_cnt    <= gap_len();
        rsp_ch.ready <= (stall_cnt == 0) && no_idle;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || psel || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, quiet);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    int n_eff;
    int items;
    int alloc_pct;
    int k;
    int b;
    int rand_items;
    int phase_no;
    int count;
    int esize;

    rand_items = 0;
    phase_no   = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset defaults, empty pool, null and unused requests
    queue_item(CMD_ALLOC, 1'b1, 10'h3FF);
    queue_item(CMD_FREE, 1'b0, 10'h3FF);
    queue_item(CMD_UNUSED, 1'b1, 10'h3FF);
    queue_item(CMD_FREE, 1'b1, 10'h3FF);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_INIT, 1'b1, 10'h155);
    queue_item(CMD_ALLOC, 1'b1, 10'h2AA);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    // double free of the same block is pushed anyway
    queue_item(CMD_FREE, 1'b1, 10'h000);
    queue_item(CMD_FREE, 1'b1, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    wait_idle();

    // Zero count leaves the list empty; widest size truncates the offset
    set_config(0, (1 << ESIZE_W) - 1);
    queue_item(CMD_INIT, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_FREE, 1'b1, 10'h3FF);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_FREE, 1'b1, 10'h200);
    queue_item(CMD_FREE, 1'b1, 10'h001);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    wait_idle();

    set_config(2, 8);
    queue_item(CMD_INIT, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    queue_item(CMD_ALLOC, 1'b0, 10'h000);
    wait_idle();

    // Random phases, each with its own setting and traffic mix
    while (rand_items < RANDOM_ITEMS) begin
      case (phase_no)
        0: begin count = 1024; esize = 4096; end
        1: begin count = 2047; esize = 8; end
        2: begin count = 1; esize = 0; end
        3: begin count = 1025; esize = (1 << ESIZE_W) - 1; end
        default: begin
          count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047)
                                              : $urandom_range(1, 16);
          case ($urandom_range(0, 4))
            0: esize = 8;
            1: esize = 64;
            2: esize = 4096;
            3: esize = (1 << ESIZE_W) - 1;
            default: esize = $urandom_range(0, (1 << ESIZE_W) - 1);
          endcase
        end
      endcase
      set_config(count, esize);
      n_eff     = (count > DEPTH) ? DEPTH : count;
      items     = $urandom_range(30, 80);
      alloc_pct = 30 + 15 * $urandom_range(0, 2);
      no_idle   = ($urandom_range(0, 3) == 0);
      phase_no++;

      // start every phase from a freshly linked pool
      queue_item(CMD_INIT, 1'($urandom_range(0, 1)), blk_t'($urandom_range(0, DEPTH - 1)));
      gen_free.delete();
      gen_held.delete();
      for (int i = 0; i < n_eff; i++) gen_free.push_back(i);

      repeat (items - 1) begin
        r = $urandom_range(0, 99);
        b = $urandom_range(0, DEPTH - 1);
        if (r < 2 && n_eff <= 64) begin
          queue_item(CMD_INIT, 1'($urandom_range(0, 1)), blk_t'(b));
          gen_free.delete();
          gen_held.delete();
          for (int i = 0; i < n_eff; i++) gen_free.push_back(i);
        end else if (r < 2 + alloc_pct) begin
          queue_item(CMD_ALLOC, 1'($urandom_range(0, 1)), blk_t'(b));
          if (gen_free.size() != 0) gen_held.push_back(gen_free.pop_front());
        end else if (r < 88) begin
          // return a block that is out, else any block
          if (gen_held.size() != 0) begin
            k = $urandom_range(0, gen_held.size() - 1);
            b = gen_held[k];
            gen_held.delete(k);
          end
          queue_item(CMD_FREE, 1'b1, blk_t'(b));
          gen_free.push_front(b);
        end else if (r < 93) begin
          queue_item(CMD_FREE, 1'b0, blk_t'(b));
        end else if (r < 97) begin
          queue_item(CMD_FREE, 1'b1, blk_t'(b));
          gen_free.push_front(b);
        end else begin
          queue_item(CMD_UNUSED, 1'($urandom_range(0, 1)), blk_t'(b));
        end
      end
      rand_items += items;
      wait_idle();
    end

    no_idle = 1'b0;
    repeat (16) @(posedge clk);
    if (err_cnt == 0 && answers_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule : tb_top
